/* src/cepi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cepi_pkg
// shared types and constants of the curvature edge pixel interpolator
// ----------------------------------------------------------------------------
package cepi_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b1;

    // threshold register
    localparam int               THRESH_W     = 8;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd30;

    // outcome of the edge-directed test
    typedef struct packed {
        logic hit;      // edge rule decides this item
        logic pick_a;   // pair a has the smaller contrast
    } t_edge_dec;

endpackage
`default_nettype wire

/* src/cepi_edge_rule.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cepi_edge_rule
// edge-directed shortcut: contrast difference test with flat-area exception
// ----------------------------------------------------------------------------
module cepi_edge_rule #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic [PIXEL_BITS-1:0]             i_a_first,
    input  wire logic [PIXEL_BITS-1:0]             i_a_second,
    input  wire logic [PIXEL_BITS-1:0]             i_b_first,
    input  wire logic [PIXEL_BITS-1:0]             i_b_second,
    input  wire logic [PIXEL_BITS:0]               i_sum_a,
    input  wire logic [PIXEL_BITS:0]               i_sum_b,
    input  wire logic                              i_edge_enable,
    input  wire logic [cepi_pkg::THRESH_W-1:0]     i_threshold,
    output cepi_pkg::t_edge_dec                    o_dec
);

    logic [PIXEL_BITS-1:0] con_a;
    logic [PIXEL_BITS-1:0] con_b;
    logic [PIXEL_BITS-1:0] con_diff;
    logic [PIXEL_BITS:0]   sum_diff;
    logic [PIXEL_BITS-1:0] tm;
    logic [PIXEL_BITS:0]   tm2;
    logic                  flat;

    always_comb begin
        con_a    = (i_a_first > i_a_second) ? (i_a_first - i_a_second)
                                            : (i_a_second - i_a_first);
        con_b    = (i_b_first > i_b_second) ? (i_b_first - i_b_second)
                                            : (i_b_second - i_b_first);
        con_diff = (con_a > con_b) ? (con_a - con_b) : (con_b - con_a);
        sum_diff = (i_sum_a > i_sum_b) ? (i_sum_a - i_sum_b) : (i_sum_b - i_sum_a);
        tm       = PIXEL_BITS'(i_threshold);
        tm2      = (PIXEL_BITS + 1)'({i_threshold, 1'b0});
        // low contrast on both pairs and similar means: leave it to curvature
        flat     = (con_a < tm) && (con_b < tm) && (sum_diff < tm2);
        o_dec.hit    = i_edge_enable && (con_diff >= tm) && !flat;
        o_dec.pick_a = (con_a < con_b);
    end

endmodule
`default_nettype wire

/* src/cepi_curv_rule.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cepi_curv_rule
// second-derivative comparison between the two candidate directions
// ----------------------------------------------------------------------------
module cepi_curv_rule #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic [PIXEL_BITS-1:0] i_far_a [4],
    input  wire logic [PIXEL_BITS-1:0] i_far_b [4],
    input  wire logic [PIXEL_BITS:0]   i_sum_a,
    input  wire logic [PIXEL_BITS:0]   i_sum_b,
    output logic                       o_pick_a
);

    localparam int HW = PIXEL_BITS + 4;

    logic [PIXEL_BITS+1:0] far_sum_a;
    logic [PIXEL_BITS+1:0] far_sum_b;
    logic signed [HW-1:0]  h_a;
    logic signed [HW-1:0]  h_b;
    logic [HW-2:0]         mag_a;
    logic [HW-2:0]         mag_b;

    always_comb begin
        far_sum_a = (PIXEL_BITS + 2)'(i_far_a[0]) + (PIXEL_BITS + 2)'(i_far_a[1])
                  + (PIXEL_BITS + 2)'(i_far_a[2]) + (PIXEL_BITS + 2)'(i_far_a[3]);
        far_sum_b = (PIXEL_BITS + 2)'(i_far_b[0]) + (PIXEL_BITS + 2)'(i_far_b[1])
                  + (PIXEL_BITS + 2)'(i_far_b[2]) + (PIXEL_BITS + 2)'(i_far_b[3]);
        // 3*s as s + 2*s
        h_a = signed'(HW'(far_sum_a)) + signed'(HW'(i_sum_a))
            - signed'(HW'(i_sum_b)) - signed'(HW'({i_sum_b, 1'b0}));
        h_b = signed'(HW'(far_sum_b)) + signed'(HW'(i_sum_b))
            - signed'(HW'(i_sum_a)) - signed'(HW'({i_sum_a, 1'b0}));
        mag_a = h_a[HW-1] ? (HW-1)'(-h_a) : h_a[HW-2:0];
        mag_b = h_b[HW-1] ? (HW-1)'(-h_b) : h_b[HW-2:0];
        // ties go to direction b
        o_pick_a = (mag_a < mag_b);
    end

endmodule
`default_nettype wire

/* src/curvature_edge_pixel_interpolator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// curvature_edge_pixel_interpolator
// one missing pixel of a doubled image from a 12-pixel neighbourhood
// ----------------------------------------------------------------------------
// Two-stage pipeline: the neighbourhood is captured in an input register, the
// edge and curvature decisions and the rounded pair mean are worked out in one
// combinational pass, and the pixel sits in an output register until taken.
// One item is accepted per clock while o_ready is high. o_valid rises once the
// item has passed from the input register into the output register. Either
// stage moves on whenever the stage after it is empty or being emptied, so a
// waiting result blocks the next item only once the input register is full.
// Configuration (index 0 edge_enable, index 1 threshold) is written through
// i_cfg_we and takes effect for items processed afterwards.
module curvature_edge_pixel_interpolator #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [cepi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [cepi_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [PIXEL_BITS-1:0]             i_near_a_first,
    input  wire logic [PIXEL_BITS-1:0]             i_near_a_second,
    input  wire logic [PIXEL_BITS-1:0]             i_near_b_first,
    input  wire logic [PIXEL_BITS-1:0]             i_near_b_second,
    input  wire logic [PIXEL_BITS-1:0]             i_far_a_0,
    input  wire logic [PIXEL_BITS-1:0]             i_far_a_1,
    input  wire logic [PIXEL_BITS-1:0]             i_far_a_2,
    input  wire logic [PIXEL_BITS-1:0]             i_far_a_3,
    input  wire logic [PIXEL_BITS-1:0]             i_far_b_0,
    input  wire logic [PIXEL_BITS-1:0]             i_far_b_1,
    input  wire logic [PIXEL_BITS-1:0]             i_far_b_2,
    input  wire logic [PIXEL_BITS-1:0]             i_far_b_3,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [PIXEL_BITS-1:0]                  o_interpolated_pixel
);

    logic                                r_edge_enable;
    logic [cepi_pkg::THRESH_W-1:0]       r_threshold;

    logic                                r_s1_valid;
    logic [PIXEL_BITS-1:0]               r_a_first;
    logic [PIXEL_BITS-1:0]               r_a_second;
    logic [PIXEL_BITS-1:0]               r_b_first;
    logic [PIXEL_BITS-1:0]               r_b_second;
    logic [PIXEL_BITS-1:0]               r_far_a [4];
    logic [PIXEL_BITS-1:0]               r_far_b [4];

    logic                                r_out_valid;
    logic [PIXEL_BITS-1:0]               r_pixel;
    logic [PIXEL_BITS-1:0]               n_pixel;

    logic                                s1_load;
    logic                                s2_load;
    logic [PIXEL_BITS:0]                 sum_a;
    logic [PIXEL_BITS:0]                 sum_b;
    logic [PIXEL_BITS:0]                 chosen;
    logic [PIXEL_BITS+1:0]               rounded;
    logic                                curv_pick_a;
    cepi_pkg::t_edge_dec                 edge_dec;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_enable <= 1'b0;
            r_threshold   <= cepi_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cepi_pkg::REG_EDGE_ENABLE: r_edge_enable <= i_cfg_data[0];
                cepi_pkg::REG_THRESHOLD:   r_threshold   <= i_cfg_data[cepi_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign s2_load = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s2_load;
    assign s1_load = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (!r_out_valid || i_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_a_first  <= i_near_a_first;
            r_a_second <= i_near_a_second;
            r_b_first  <= i_near_b_first;
            r_b_second <= i_near_b_second;
            r_far_a[0] <= i_far_a_0;
            r_far_a[1] <= i_far_a_1;
            r_far_a[2] <= i_far_a_2;
            r_far_a[3] <= i_far_a_3;
            r_far_b[0] <= i_far_b_0;
            r_far_b[1] <= i_far_b_1;
            r_far_b[2] <= i_far_b_2;
            r_far_b[3] <= i_far_b_3;
        end
    end

    assign sum_a = (PIXEL_BITS + 1)'(r_a_first) + (PIXEL_BITS + 1)'(r_a_second);
    assign sum_b = (PIXEL_BITS + 1)'(r_b_first) + (PIXEL_BITS + 1)'(r_b_second);

    cepi_edge_rule #(
        .PIXEL_BITS    (PIXEL_BITS)
    ) u_edge (
        .i_a_first     (r_a_first),
        .i_a_second    (r_a_second),
        .i_b_first     (r_b_first),
        .i_b_second    (r_b_second),
        .i_sum_a       (sum_a),
        .i_sum_b       (sum_b),
        .i_edge_enable (r_edge_enable),
        .i_threshold   (r_threshold),
        .o_dec         (edge_dec)
    );

    cepi_curv_rule #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_curv (
        .i_far_a    (r_far_a),
        .i_far_b    (r_far_b),
        .i_sum_a    (sum_a),
        .i_sum_b    (sum_b),
        .o_pick_a   (curv_pick_a)
    );

    always_comb begin
        if (edge_dec.hit) begin
            chosen = edge_dec.pick_a ? sum_a : sum_b;
        end else begin
            chosen = curv_pick_a ? sum_a : sum_b;
        end
        // rounded mean, (sum + 1) >> 1
        rounded = (PIXEL_BITS + 2)'(chosen) + (PIXEL_BITS + 2)'(1);
        n_pixel = rounded[PIXEL_BITS:1];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_interpolated_pixel = r_pixel;

endmodule
`default_nettype wire
